>>> hdl/gbn_pkg.sv
// Go-Back-N sender: shared types, field widths and codes.
// No dependencies; imported by every other file of the block but gbn_ram.
package gbn_pkg;

    localparam int SEQ_W      = 10;
    localparam int MOD_W      = 11;
    localparam int TAG_W      = 16;
    localparam int LEN_W      = 5;
    localparam int SUM_W      = 13;
    localparam int CK_W       = 13;
    localparam int TMO_W      = 16;
    localparam int WSZ_W      = 4;
    localparam int ACKCK_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [LEN_W-1:0] PAYLOAD_BYTES = 5'd20;
    localparam logic [MOD_W-1:0] MOD_MAX       = 11'd1024;

    localparam logic [1:0] KIND_MSG    = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_EXPIRY = 2'd2;

    localparam logic [2:0] OUT_NEW    = 3'd0;
    localparam logic [2:0] OUT_RESEND = 3'd1;
    localparam logic [2:0] OUT_START  = 3'd2;
    localparam logic [2:0] OUT_STOP   = 3'd3;
    localparam logic [2:0] OUT_DROP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [TAG_W-1:0]   msg_tag;
        logic [LEN_W-1:0]   msg_length;
        logic [SUM_W-1:0]   payload_sum;
        logic [SEQ_W-1:0]   ack_seq;
        logic [SEQ_W-1:0]   ack_number;
        logic [ACKCK_W-1:0] ack_checksum;
    } t_item;

    typedef struct packed {
        logic [2:0]       out_kind;
        logic [SEQ_W-1:0] seq_number;
        logic [TAG_W-1:0] out_tag;
        logic [LEN_W-1:0] out_length;
        logic [CK_W-1:0]  checksum;
        logic [TMO_W-1:0] timer_value;
        logic             last;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] wdata;
    } t_cfg_wr;

    typedef struct packed {
        logic [TAG_W-1:0] tag;
        logic [LEN_W-1:0] len;
        logic [SUM_W-1:0] sum;
    } t_desc;

    localparam int DESC_W = $bits(t_desc);

    typedef struct packed {
        logic load;
        logic mod_init;
        logic mod_step;
        logic fix;
        logic enqueue;
        logic qread;
        logic send;
        logic stop;
        logic start;
        logic drop;
        logic rs_init;
        logic wread;
        logic resend;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       out_free;
        logic       dirty;
        logic       mod_done;
        logic       queue_full;
        logic       queue_nonempty;
        logic       win_room;
        logic       win_empty;
        logic       was_empty;
        logic       ack_ok;
        logic       stop_last;
        logic       resend_final;
    } t_stat;

endpackage

>>> hdl/gbn_if.sv
// Go-Back-N sender: valid/ready channel interfaces for items, results and
// configuration writes. Depends on gbn_pkg.
interface gbn_in_if import gbn_pkg::*; ();
    logic  valid;
    logic  ready;
    t_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbn_out_if import gbn_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
    logic    valid;
    logic    ready;
    t_cfg_wr data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/gbn_ram.sv
// Go-Back-N sender: generic single write port RAM with registered read.
// No dependencies.
module gbn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/gbn_dpath.sv
// Go-Back-N sender datapath: config registers, window and queue pointers,
// modulo unit, queue and window RAMs, result register. Uses gbn_pkg, gbn_ram.
module gbn_dpath import gbn_pkg::*; #(
    parameter int MAX_WINDOW  = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_item   i_item,
    input  logic    i_cfg_we,
    input  t_cfg_wr i_cfg,
    input  t_cmd    i_cmd,
    output t_stat   o_stat,
    output logic    o_res_valid,
    output t_result o_res,
    input  logic    i_res_ready
);

    localparam int WA = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WC = $clog2(MAX_WINDOW + 1);
    localparam int QA = $clog2(QUEUE_DEPTH);
    localparam int QC = $clog2(QUEUE_DEPTH + 1);
    localparam logic [MOD_W-1:0] MOD_MIN = MOD_W'(MAX_WINDOW + 1);
    localparam logic [MOD_W-1:0] MW_E    = MOD_W'(MAX_WINDOW);

    logic [WSZ_W-1:0] r_win_size;
    logic [MOD_W-1:0] r_modulus;
    logic [TMO_W-1:0] r_timeout;
    logic             r_dirty;
    logic [SEQ_W-1:0] r_base;
    logic [SEQ_W-1:0] r_next;
    logic [WA-1:0]    r_slot;
    logic [QA-1:0]    r_head;
    logic [QC-1:0]    r_count;
    logic             r_was_empty;
    logic [MOD_W-1:0] r_rem;
    logic [3:0]       r_bit;
    logic             r_which;
    logic [WC-1:0]    r_i;
    logic [WA-1:0]    r_ridx;
    logic [SEQ_W-1:0] r_rseq;
    logic             r_res_valid;
    t_result          r_res;
    t_item            r_item;

    logic [MOD_W-1:0] m;
    logic [MOD_W-1:0] w_e;
    logic [MOD_W-1:0] ws_e;
    logic [MOD_W-1:0] diff;
    logic [MOD_W-1:0] inflight_e;
    logic [SEQ_W-1:0] inflight;
    logic [MOD_W-1:0] fix_tgt;
    logic [SEQ_W-1:0] fix_seq;
    logic [SEQ_W-1:0] mod_src;
    logic [MOD_W-1:0] rem_sh;
    logic [MOD_W-1:0] rem_n;
    logic [LEN_W-1:0] len_sat;
    logic [QA:0]      qw_sum;
    logic [QA-1:0]    q_waddr;
    logic [WA:0]      ww_sum;
    logic [WA-1:0]    w_waddr;
    logic [ACKCK_W-1:0] ack_ck;
    logic [MOD_W-1:0] anum_e;
    logic [MOD_W-1:0] base_e;
    logic [MOD_W-1:0] d_e;
    logic [MOD_W-1:0] anum_inc;
    logic [SEQ_W-1:0] base_new;
    logic [WA:0]      slot_sum;
    logic [WA-1:0]    slot_new;
    logic [SEQ_W-1:0] next_inc;
    logic [SEQ_W-1:0] rseq_inc;
    t_desc            q_rd;
    t_desc            w_rd;
    t_desc            q_wd;

    always_comb begin
        if (r_modulus < MOD_MIN) begin
            m = MOD_MIN;
        end else if (r_modulus > MOD_MAX) begin
            m = MOD_MAX;
        end else begin
            m = r_modulus;
        end
        ws_e = MOD_W'(r_win_size);
        if (ws_e == '0) begin
            w_e = MOD_W'(1);
        end else if (ws_e > MW_E) begin
            w_e = MW_E;
        end else begin
            w_e = ws_e;
        end
    end

    assign base_e     = {1'b0, r_base};
    assign diff       = {1'b0, r_next} - base_e;
    assign inflight_e = (r_next >= r_base) ? diff : diff + m;
    assign inflight   = inflight_e[SEQ_W-1:0];

    assign fix_tgt = base_e + MW_E;
    assign fix_seq = (fix_tgt >= m) ? SEQ_W'(fix_tgt - m) : fix_tgt[SEQ_W-1:0];

    // one remainder bit per cycle, base first then next
    assign mod_src = r_which ? r_next : r_base;
    assign rem_sh  = {r_rem[SEQ_W-1:0], mod_src[r_bit]};
    assign rem_n   = (rem_sh >= m) ? rem_sh - m : rem_sh;

    assign len_sat = (r_item.msg_length > PAYLOAD_BYTES) ? PAYLOAD_BYTES
                                                         : r_item.msg_length;

    assign qw_sum  = (QA+1)'(r_head) + (QA+1)'(r_count);
    assign q_waddr = (qw_sum >= (QA+1)'(QUEUE_DEPTH)) ?
                     QA'(qw_sum - (QA+1)'(QUEUE_DEPTH)) : qw_sum[QA-1:0];

    assign ww_sum  = (WA+1)'(r_slot) + (WA+1)'(inflight);
    assign w_waddr = (ww_sum >= (WA+1)'(MAX_WINDOW)) ?
                     WA'(ww_sum - (WA+1)'(MAX_WINDOW)) : ww_sum[WA-1:0];

    assign ack_ck = ACKCK_W'(r_item.ack_seq) + ACKCK_W'(r_item.ack_number)
                  + ACKCK_W'(r_item.payload_sum);
    assign anum_e = {1'b0, r_item.ack_number};
    assign d_e    = (anum_e >= base_e) ? anum_e - base_e : anum_e + m - base_e;

    assign anum_inc = anum_e + MOD_W'(1);
    assign base_new = (anum_inc == m) ? '0 : anum_inc[SEQ_W-1:0];
    assign slot_sum = (WA+1)'(r_slot) + (WA+1)'(d_e) + (WA+1)'(1);
    assign slot_new = (slot_sum >= (WA+1)'(MAX_WINDOW)) ?
                      WA'(slot_sum - (WA+1)'(MAX_WINDOW)) : slot_sum[WA-1:0];

    assign next_inc = ({1'b0, r_next} + MOD_W'(1) == m) ? '0 : r_next + SEQ_W'(1);
    assign rseq_inc = ({1'b0, r_rseq} + MOD_W'(1) == m) ? '0 : r_rseq + SEQ_W'(1);

    assign q_wd = '{tag: r_item.msg_tag, len: len_sat, sum: r_item.payload_sum};

    gbn_ram #(.WIDTH(DESC_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.enqueue),
        .i_waddr (q_waddr),
        .i_wdata (q_wd),
        .i_re    (i_cmd.qread),
        .i_raddr (r_head),
        .o_rdata (q_rd)
    );

    gbn_ram #(.WIDTH(DESC_W), .DEPTH(MAX_WINDOW)) u_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.send),
        .i_waddr (w_waddr),
        .i_wdata (q_rd),
        .i_re    (i_cmd.wread),
        .i_raddr (r_ridx),
        .o_rdata (w_rd)
    );

    always_comb begin
        o_stat.kind           = r_item.kind;
        o_stat.out_free       = !r_res_valid || i_res_ready;
        o_stat.dirty          = r_dirty;
        o_stat.mod_done       = r_which && (r_bit == '0);
        o_stat.queue_full     = (r_count == QC'(QUEUE_DEPTH));
        o_stat.queue_nonempty = (r_count != '0);
        o_stat.win_room       = (inflight_e < w_e);
        o_stat.win_empty      = (inflight == '0);
        o_stat.was_empty      = r_was_empty;
        o_stat.ack_ok         = (ack_ck == r_item.ack_checksum) && (anum_e < m)
                              && (d_e < inflight_e);
        o_stat.stop_last      = (r_count == '0) && (d_e + MOD_W'(1) == inflight_e);
        o_stat.resend_final   = (MOD_W'(r_i) + MOD_W'(1) == inflight_e);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size  <= WSZ_W'(8);
            r_modulus   <= MOD_W'(1000);
            r_timeout   <= TMO_W'(20);
            r_dirty     <= 1'b0;
            r_base      <= '0;
            r_next      <= '0;
            r_slot      <= '0;
            r_head      <= '0;
            r_count     <= '0;
            r_which     <= 1'b0;
            r_bit       <= '0;
            r_res_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg.index)
                    CFG_WINDOW: begin
                        r_win_size <= i_cfg.wdata[WSZ_W-1:0];
                    end
                    CFG_MODULUS: begin
                        r_modulus <= i_cfg.wdata[MOD_W-1:0];
                        r_dirty   <= 1'b1;
                    end
                    CFG_TIMEOUT: begin
                        r_timeout <= i_cfg.wdata[TMO_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.mod_init) begin
                r_which <= 1'b0;
                r_bit   <= 4'(SEQ_W - 1);
            end
            if (i_cmd.mod_step) begin
                if (r_bit == '0) begin
                    if (r_which) begin
                        r_next  <= rem_n[SEQ_W-1:0];
                        r_dirty <= 1'b0;
                    end else begin
                        r_base <= rem_n[SEQ_W-1:0];
                    end
                    r_which <= 1'b1;
                    r_bit   <= 4'(SEQ_W - 1);
                end else begin
                    r_bit <= r_bit - 4'd1;
                end
            end
            if (i_cmd.fix && (inflight_e > MW_E)) begin
                r_next <= fix_seq;
            end
            if (i_cmd.enqueue) begin
                r_count <= r_count + QC'(1);
            end
            if (i_cmd.send) begin
                r_next  <= next_inc;
                r_head  <= (r_head == QA'(QUEUE_DEPTH - 1)) ? '0 : r_head + QA'(1);
                r_count <= r_count - QC'(1);
            end
            if (i_cmd.stop) begin
                r_base <= base_new;
                r_slot <= slot_new;
            end
            if (i_cmd.send || i_cmd.stop || i_cmd.start || i_cmd.drop
                    || i_cmd.resend) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_item;
        end
        if (i_cmd.mod_init) begin
            r_rem <= '0;
        end else if (i_cmd.mod_step) begin
            r_rem <= (r_bit == '0) ? '0 : rem_n;
        end
        if (i_cmd.enqueue) begin
            r_was_empty <= (r_next == r_base);
        end
        if (i_cmd.rs_init) begin
            r_i    <= '0;
            r_ridx <= r_slot;
            r_rseq <= r_base;
        end else if (i_cmd.resend) begin
            r_i    <= r_i + WC'(1);
            r_ridx <= (r_ridx == WA'(MAX_WINDOW - 1)) ? '0 : r_ridx + WA'(1);
            r_rseq <= rseq_inc;
        end
        if (i_cmd.send) begin
            r_res <= '{out_kind: OUT_NEW, seq_number: r_next, out_tag: q_rd.tag,
                       out_length: q_rd.len, checksum: CK_W'(r_next) + q_rd.sum,
                       timer_value: '0, last: i_cmd.last};
        end else if (i_cmd.resend) begin
            r_res <= '{out_kind: OUT_RESEND, seq_number: r_rseq, out_tag: w_rd.tag,
                       out_length: w_rd.len, checksum: CK_W'(r_rseq) + w_rd.sum,
                       timer_value: '0, last: i_cmd.last};
        end else if (i_cmd.stop) begin
            r_res <= '{out_kind: OUT_STOP, seq_number: '0, out_tag: '0,
                       out_length: '0, checksum: '0, timer_value: '0,
                       last: i_cmd.last};
        end else if (i_cmd.start) begin
            r_res <= '{out_kind: OUT_START, seq_number: '0, out_tag: '0,
                       out_length: '0, checksum: '0, timer_value: r_timeout,
                       last: i_cmd.last};
        end else if (i_cmd.drop) begin
            r_res <= '{out_kind: OUT_DROP, seq_number: '0, out_tag: r_item.msg_tag,
                       out_length: len_sat, checksum: '0, timer_value: '0,
                       last: i_cmd.last};
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> hdl/gbn_ctrl.sv
// Go-Back-N sender controller: sequences each item through the datapath.
// Uses gbn_pkg command and status structs.
module gbn_ctrl import gbn_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_MOD_INIT = 13'b0000000000010,
        S_MOD      = 13'b0000000000100,
        S_FIX      = 13'b0000000001000,
        S_DISPATCH = 13'b0000000010000,
        S_DROP     = 13'b0000000100000,
        S_QREAD    = 13'b0000001000000,
        S_SEND     = 13'b0000010000000,
        S_ACKLOOP  = 13'b0000100000000,
        S_STOP     = 13'b0001000000000,
        S_TIMER    = 13'b0010000000000,
        S_WREAD    = 13'b0100000000000,
        S_RESEND   = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_ack_mode;
    logic   n_ack_mode;

    always_comb begin
        n_state    = r_state;
        n_ack_mode = r_ack_mode;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.dirty ? S_MOD_INIT : S_FIX;
                end
            end
            S_MOD_INIT: begin
                o_cmd.mod_init = 1'b1;
                n_state        = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_stat.mod_done) begin
                    n_state = S_FIX;
                end
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_DISPATCH;
            end
            S_DISPATCH: begin
                unique case (i_stat.kind)
                    KIND_MSG: begin
                        n_ack_mode = 1'b0;
                        if (i_stat.queue_full) begin
                            n_state = S_DROP;
                        end else begin
                            o_cmd.enqueue = 1'b1;
                            n_state = i_stat.win_room ? S_QREAD : S_IDLE;
                        end
                    end
                    KIND_ACK: begin
                        n_ack_mode = 1'b1;
                        n_state    = i_stat.ack_ok ? S_STOP : S_IDLE;
                    end
                    KIND_EXPIRY: begin
                        if (i_stat.win_empty) begin
                            n_state = S_TIMER;
                        end else begin
                            o_cmd.rs_init = 1'b1;
                            n_state       = S_WREAD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_DROP: begin
                if (i_stat.out_free) begin
                    o_cmd.drop = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_QREAD: begin
                o_cmd.qread = 1'b1;
                n_state     = S_SEND;
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.send = 1'b1;
                    o_cmd.last = !r_ack_mode && !i_stat.was_empty;
                    if (r_ack_mode) begin
                        n_state = S_ACKLOOP;
                    end else begin
                        n_state = i_stat.was_empty ? S_TIMER : S_IDLE;
                    end
                end
            end
            S_ACKLOOP: begin
                if (i_stat.queue_nonempty && i_stat.win_room) begin
                    n_state = S_QREAD;
                end else if (!i_stat.win_empty) begin
                    n_state = S_TIMER;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_STOP: begin
                if (i_stat.out_free) begin
                    o_cmd.stop = 1'b1;
                    o_cmd.last = i_stat.stop_last;
                    n_state    = S_ACKLOOP;
                end
            end
            S_TIMER: begin
                if (i_stat.out_free) begin
                    o_cmd.start = 1'b1;
                    o_cmd.last  = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_WREAD: begin
                o_cmd.wread = 1'b1;
                n_state     = S_RESEND;
            end
            S_RESEND: begin
                if (i_stat.out_free) begin
                    o_cmd.resend = 1'b1;
                    n_state      = i_stat.resend_final ? S_TIMER : S_WREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ack_mode <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_ack_mode <= n_ack_mode;
        end
    end

endmodule

>>> hdl/go_back_n_sender.sv
// Go-Back-N sender top level: controller plus datapath, item, result and
// config channels. Uses gbn_pkg, gbn_if, gbn_ctrl, gbn_dpath.
// A new message is loaded, queued, read back from the queue and registered as
// its data packet when the window has room. Each result waits for a free result
// register. After a modulus write the next item first reduces the base and next
// pointers to the new modulus, one bit at a time. Reset: sync, active low.
module go_back_n_sender import gbn_pkg::*; #(
    parameter int MAX_WINDOW  = 8,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gbn_in_if.sink    i_in,
    gbn_out_if.source o_out,
    gbn_cfg_if.sink   i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;

    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    gbn_dpath #(.MAX_WINDOW(MAX_WINDOW), .QUEUE_DEPTH(QUEUE_DEPTH)) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_in.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg       (i_cfg.data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_res_valid (o_out.valid),
        .o_res       (o_out.data),
        .i_res_ready (o_out.ready)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("item accepted while previous one still in work");

    a_not_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.data.last |-> !i_in.ready)
        else $error("idle with results of an item outstanding");

    a_data_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.data.out_kind == OUT_NEW
                        || o_out.data.out_kind == OUT_RESEND)
        |-> o_out.data.timer_value == '0)
        else $error("data packet carries a timer value");

endmodule

>>> test/tb.sv
// Testbench for go_back_n_sender: directed and random message, ack and expiry
// items, checked against a cycle-free behavioural predictor of the sender.
// Depends on gbn_pkg, gbn_if and the go_back_n_sender RTL.
module tb;
    import gbn_pkg::*;

    localparam int WIN_MAX = 8;
    localparam int QDEPTH  = 64;
    localparam int LIMIT   = 1000000;
    localparam int SETTLE  = 40;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gbn_in_if  in_ch ();
    gbn_out_if out_ch ();
    gbn_cfg_if cfg_ch ();

    go_back_n_sender dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #1 i_clk = ~i_clk;

    // predictor state
    logic [3:0]  win_reg;
    logic [10:0] mod_reg;
    logic [15:0] tmo_reg;
    int          base, nseq, wslot, qhead, qcount;
    t_desc       win_mem [WIN_MAX];
    bit          win_written [WIN_MAX];
    t_desc       pend_mem [QDEPTH];
    t_result     sent_q [$];

    int errors = 0;
    int cycles = 0;
    int hold_cycles = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int modulus();
        int m;
        m = mod_reg;
        if (m < WIN_MAX + 1) m = WIN_MAX + 1;
        if (m > 1024) m = 1024;
        return m;
    endfunction

    function automatic int window();
        int w;
        w = win_reg;
        if (w < 1) w = 1;
        if (w > WIN_MAX) w = WIN_MAX;
        return w;
    endfunction

    function automatic int in_flight();
        int m;
        m = modulus();
        return (nseq + m - base) % m;
    endfunction

    // reduction of the pointers to the current sequence space (idempotent)
    function automatic void fold_seq();
        int m;
        m = modulus();
        base = base % m;
        nseq = nseq % m;
        if (in_flight() > WIN_MAX) nseq = (base + WIN_MAX) % m;
    endfunction

    function automatic void push_res(logic [2:0] k, int seq, logic [15:0] tag,
                                     logic [4:0] len, int ck, logic [15:0] tv);
        t_result r;
        r.out_kind    = k;
        r.seq_number  = seq[9:0];
        r.out_tag     = tag;
        r.out_length  = len;
        r.checksum    = ck[12:0];
        r.timer_value = tv;
        r.last        = 1'b0;
        sent_q.push_back(r);
    endfunction

    function automatic void send_head();
        t_desc e;
        int    s;
        int    m;
        m = modulus();
        e = pend_mem[qhead];
        s = nseq;
        win_mem[(wslot + in_flight()) % WIN_MAX]     = e;
        win_written[(wslot + in_flight()) % WIN_MAX] = 1'b1;
        push_res(OUT_NEW, s, e.tag, e.len, s + e.sum, '0);
        nseq   = (s + 1) % m;
        qhead  = (qhead + 1) % QDEPTH;
        qcount = qcount - 1;
    endfunction

    function automatic void predict_item(t_item it);
        int    m, w, n0, d, n;
        t_desc e;
        bit    was_empty;
        m  = modulus();
        w  = window();
        n0 = sent_q.size();
        fold_seq();
        if (it.kind == KIND_MSG) begin
            e.tag = it.msg_tag;
            e.len = (it.msg_length > PAYLOAD_BYTES) ? PAYLOAD_BYTES : it.msg_length;
            e.sum = it.payload_sum;
            if (qcount >= QDEPTH) begin
                push_res(OUT_DROP, 0, e.tag, e.len, 0, '0);
            end else begin
                pend_mem[(qhead + qcount) % QDEPTH] = e;
                qcount++;
                if (in_flight() < w) begin
                    was_empty = (nseq == base);
                    send_head();
                    if (was_empty) push_res(OUT_START, 0, '0, '0, 0, tmo_reg);
                end
            end
        end else if (it.kind == KIND_ACK) begin
            if (int'(it.ack_seq) + int'(it.ack_number) + int'(it.payload_sum)
                    == int'(it.ack_checksum) && it.ack_number < m) begin
                d = (int'(it.ack_number) + m - base) % m;
                if (d < in_flight()) begin
                    push_res(OUT_STOP, 0, '0, '0, 0, '0);
                    wslot = (wslot + d + 1) % WIN_MAX;
                    base  = (int'(it.ack_number) + 1) % m;
                    while (qcount > 0 && in_flight() < w) send_head();
                    if (base != nseq) push_res(OUT_START, 0, '0, '0, 0, tmo_reg);
                end
            end
        end else if (it.kind == KIND_EXPIRY) begin
            n = in_flight();
            for (int i = 0; i < n; i++) begin
                e = win_mem[(wslot + i) % WIN_MAX];
                push_res(OUT_RESEND, (base + i) % m, e.tag, e.len,
                         (base + i) % m + e.sum, '0);
            end
            push_res(OUT_START, 0, '0, '0, 0, tmo_reg);
        end
        if (sent_q.size() > n0) sent_q[$].last = 1'b1;
    endfunction

    function automatic bit resend_safe();
        fold_seq();
        for (int i = 0; i < in_flight(); i++)
            if (!win_written[(wslot + i) % WIN_MAX]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_item make_msg(bit wide);
        t_item it;
        it = t_item'({$urandom, $urandom});
        it.kind        = KIND_MSG;
        it.msg_length  = wide ? 5'($urandom) : 5'($urandom_range(0, 20));
        it.payload_sum = wide ? 13'($urandom) : 13'($urandom_range(0, 5100));
        return it;
    endfunction

    // flavour: 0 good, 1 wrong checksum, 2 number beyond space, 3 not outstanding
    function automatic t_item make_ack(int flavour);
        t_item it;
        int    m, n, num;
        it = t_item'({$urandom, $urandom});
        it.kind = KIND_ACK;
        fold_seq();
        m = modulus();
        n = in_flight();
        if (flavour == 0 && n == 0) flavour = 3;
        if (flavour == 2 && m >= 1024) flavour = 1;
        case (flavour)
            0: num = (base + $urandom_range(0, n - 1)) % m;
            2: num = $urandom_range(m, 1023);
            3: num = (base + n + $urandom_range(0, m - n - 1)) % m;
            default: num = $urandom_range(0, m - 1);
        endcase
        it.ack_number   = num[9:0];
        it.ack_checksum = 16'(int'(it.ack_seq) + num + int'(it.payload_sum));
        if (flavour == 1) it.ack_checksum = it.ack_checksum + 16'($urandom_range(1, 9));
        return it;
    endfunction

    function automatic t_item make_expiry();
        t_item it;
        it = t_item'({$urandom, $urandom});
        it.kind = resend_safe() ? KIND_EXPIRY : KIND_UNUSED;
        return it;
    endfunction

    task automatic send_item(t_item it, bit idle_ok);
        int gap;
        gap = 0;
        if (idle_ok && $urandom_range(0, 1))
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (!in_ch.ready);
        if (it.kind == KIND_EXPIRY && !resend_safe()) it.kind = KIND_UNUSED;
        predict_item(it);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sent_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.data.index <= idx;
        cfg_ch.data.wdata <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            CFG_WINDOW:  win_reg = val[3:0];
            CFG_MODULUS: mod_reg = val[10:0];
            CFG_TIMEOUT: tmo_reg = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // result receiver with random stalls and an optional long hold-off
    initial begin
        forever begin
            if (hold_cycles > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_cycles) @(posedge i_clk);
                hold_cycles = 0;
            end else if ($urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(15, 50)
                                                     : $urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result e, a;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            a = out_ch.data;
            if (sent_q.size() == 0) begin
                $error("unexpected result kind %0d", a.out_kind);
                errors++;
            end else begin
                e = sent_q.pop_front();
                if (a.out_kind !== e.out_kind) begin
                    $error("out_kind exp %0d got %0d", e.out_kind, a.out_kind); errors++;
                end
                if (a.seq_number !== e.seq_number) begin
                    $error("seq_number exp %0d got %0d", e.seq_number, a.seq_number); errors++;
                end
                if (a.out_tag !== e.out_tag) begin
                    $error("out_tag exp %0h got %0h", e.out_tag, a.out_tag); errors++;
                end
                if (a.out_length !== e.out_length) begin
                    $error("out_length exp %0d got %0d", e.out_length, a.out_length); errors++;
                end
                if (a.checksum !== e.checksum) begin
                    $error("checksum exp %0d got %0d", e.checksum, a.checksum); errors++;
                end
                if (a.timer_value !== e.timer_value) begin
                    $error("timer_value exp %0d got %0d", e.timer_value, a.timer_value); errors++;
                end
                if (a.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, a.last); errors++;
                end
            end
        end
    end

    task automatic test_directed();
        t_item it;
        it = make_expiry();                      // expiry, empty window
        send_item(it, 1'b0);
        for (int i = 0; i < 9; i++) begin        // fill window, one waits
            it = make_msg(1'b0);
            if (i == 0) begin
                it.msg_tag = '0; it.msg_length = '0; it.payload_sum = '0;
            end else if (i == 1) begin
                it.msg_tag = '1; it.msg_length = '1; it.payload_sum = '1;
            end else if (i == 2) begin
                it.msg_length = 5'd20; it.payload_sum = 13'd5100;
            end
            send_item(it, 1'b0);
        end
        send_item(make_ack(1), 1'b0);
        send_item(make_ack(2), 1'b0);
        send_item(make_ack(3), 1'b0);
        send_item(make_expiry(), 1'b0);
        send_item(make_ack(0), 1'b0);
        it = make_msg(1'b0);
        it.kind = KIND_UNUSED;
        send_item(it, 1'b0);
        send_item(make_expiry(), 1'b0);
        it = make_ack(0);                        // ack the newest: window slides fully
        fold_seq();
        it.ack_number   = 10'((nseq + modulus() - 1) % modulus());
        it.ack_checksum = 16'(int'(it.ack_seq) + int'(it.ack_number) + int'(it.payload_sum));
        send_item(it, 1'b0);
        drain();
    endtask

    task automatic test_config_extremes();
        write_reg(CFG_WINDOW, 16'd0);
        write_reg(CFG_MODULUS, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd0);
        for (int i = 0; i < 12; i++) send_item(make_msg(1'b1), 1'b1);
        send_item(make_expiry(), 1'b1);
        for (int i = 0; i < 12; i++) send_item(make_ack(0), 1'b1);
        drain();
        write_reg(CFG_WINDOW, 16'hFFFF);
        write_reg(CFG_MODULUS, 16'hFFFF);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        for (int i = 0; i < 10; i++) send_item(make_msg(1'b1), 1'b1);
        drain();
        // modulus shrinks with packets in flight
        write_reg(CFG_MODULUS, 16'd9);
        send_item(make_expiry(), 1'b1);
        for (int i = 0; i < 6; i++) send_item(make_ack(0), 1'b1);
        drain();
    endtask

    task automatic test_queue_full();
        write_reg(CFG_WINDOW, 16'd8);
        write_reg(CFG_MODULUS, 16'd1000);
        hold_cycles = 400;
        for (int i = 0; i < 80; i++) send_item(make_msg(1'b0), 1'b0);
        drain();
    endtask

    task automatic test_random();
        int r;
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_WINDOW, 16'($urandom_range(1, 8)));
            write_reg(CFG_MODULUS, 16'(ph == 0 ? 1024 : $urandom_range(9, 1024)));
            write_reg(CFG_TIMEOUT, 16'($urandom_range(1, 65535)));
            for (int i = 0; i < 42; i++) begin
                r = $urandom_range(0, 99);
                if (r < 45)      send_item(make_msg(r < 3), 1'b1);
                else if (r < 80) send_item(make_ack(0), 1'b1);
                else if (r < 89) send_item(make_ack($urandom_range(1, 3)), 1'b1);
                else             send_item(make_expiry(), 1'b1);
            end
            drain();
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        win_reg = 4'd8;
        mod_reg = 11'd1000;
        tmo_reg = 16'd20;
        base = 0; nseq = 0; wslot = 0; qhead = 0; qcount = 0;
        foreach (win_written[i]) win_written[i] = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_queue_full();
        test_random();
        drain();
        if (errors == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end
endmodule
